[rtl/lss_pkg.sv]
package lss_pkg;

    // Build-time defaults
    localparam int DEPTH_DEF = 8;

    // Field widths
    localparam int REQ_W  = 3;
    localparam int WORD_W = 32;
    localparam int POS_W  = 3;
    localparam int ST_W   = 2;

    typedef logic [REQ_W-1:0]         t_req;
    typedef logic [ST_W-1:0]          t_status;
    typedef logic signed [WORD_W-1:0] t_word;
    typedef logic [POS_W-1:0]         t_pos;

    // Request codes
    localparam t_req REQ_PUSH   = 3'd0;
    localparam t_req REQ_POP    = 3'd1;
    localparam t_req REQ_PEEK   = 3'd2;
    localparam t_req REQ_DISP   = 3'd3;
    localparam t_req REQ_DRAIN  = 3'd4;
    localparam t_req REQ_SEARCH = 3'd5;

    // Status codes
    localparam t_status ST_OK       = 2'd0;
    localparam t_status ST_OVERFLOW = 2'd1;
    localparam t_status ST_UNDERFLW = 2'd2;
    localparam t_status ST_NOTFOUND = 2'd3;

    // Sequencer to walk unit
    typedef struct packed {
        logic down;    // walk top-down
        logic single;  // one entry only (pop, peek)
    } t_walk_ctl;

    // Walk unit to sequencer
    typedef struct packed {
        logic match;   // word equals key
        logic at_end;  // this entry is the final one of the walk
    } t_walk_sts;

endpackage

[rtl/lss_if.sv]
// Request channel
interface lss_in_if;
    import lss_pkg::*;

    logic  valid;
    logic  ready;
    t_req  req_type;
    t_word value;

    modport source (output valid, output req_type, output value, input ready);
    modport sink   (input valid, input req_type, input value, output ready);
endinterface

// Result channel
interface lss_out_if;
    import lss_pkg::*;

    logic    valid;
    logic    ready;
    t_status status;
    t_word   data;
    t_pos    position;
    logic    last;

    modport source (output valid, output status, output data, output position,
                    output last, input ready);
    modport sink   (input valid, input status, input data, input position,
                    input last, output ready);
endinterface

[rtl/lifo_stack_with_search.sv]
// Channel  | Dir | Payload                          | Transfer
// i_req    | in  | req_type[2:0], value[31:0]       | valid && ready
// o_res    | out | status[1:0], data[31:0],         | valid && ready
//          |     | position[2:0], last              |
//
// Push, overflow, underflow: result registered as the request is taken;
// ignored codes give none. Pop and peek pass S_ADDR and S_DATA once, display
// and drain once per entry, search once per entry then S_DONE, set by the
// single RAM read port and the one shared compare/step unit. A busy port
// holds the walk only where a result is due. Reset (synchronous) empties
// the stack; entry contents are not cleared. Requests are taken only while
// the sequencer is idle and the result register is free or being emptied.
module lifo_stack_with_search #(
    parameter int DEPTH = lss_pkg::DEPTH_DEF
) (
    input  logic    i_clk,
    input  logic    i_rst_n,
    lss_in_if.sink  i_req,
    lss_out_if.source o_res
);
    import lss_pkg::*;

    localparam int IW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    // Sequencer states
    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_ADDR = 2'd1;
    localparam logic [1:0] S_DATA = 2'd2;
    localparam logic [1:0] S_DONE = 2'd3;

    // Control registers
    logic [1:0]    r_state, n_state;
    logic [CW-1:0] r_cnt, n_cnt;
    logic          r_ov, n_ov;
    logic          r_have_pend, n_have_pend;

    // Payload registers
    t_req          r_req, n_req;
    t_word         r_key, n_key;
    logic [IW-1:0] r_idx, n_idx;
    logic [IW-1:0] r_last_idx, n_last_idx;
    logic [IW-1:0] r_pend, n_pend;
    t_status       r_status, n_status;
    t_word         r_data, n_data;
    t_pos          r_pos, n_pos;
    logic          r_last, n_last;

    logic          w_out_free;
    logic          w_in_fire;
    logic          w_full;
    logic          w_we;
    logic          w_re;
    logic [CW-1:0] w_cnt_m1;
    t_word         w_rdata;
    t_walk_ctl     w_ctl;
    t_walk_sts     w_sts;
    logic [IW-1:0] w_nxt;
    logic          w_stall;

    function automatic t_pos f_pos(input logic [IW-1:0] idx);
        logic [IW+POS_W-1:0] ext;
        ext = {{POS_W{1'b0}}, idx};
        return ext[POS_W-1:0];
    endfunction

    // Handshake
    assign w_out_free  = !r_ov || o_res.ready;
    assign i_req.ready = (r_state == S_IDLE) && w_out_free;
    assign w_in_fire   = i_req.valid && i_req.ready;
    assign w_full      = (r_cnt == CW'(DEPTH));
    assign w_cnt_m1    = r_cnt - CW'(1);

    // Entry store
    assign w_we = w_in_fire && (i_req.req_type == REQ_PUSH) && !w_full;
    assign w_re = (r_state == S_ADDR);

    lss_ram #(
        .WIDTH (WORD_W),
        .DEPTH (DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (r_cnt[IW-1:0]),
        .i_wdata (i_req.value),
        .i_re    (w_re),
        .i_raddr (r_idx),
        .o_rdata (w_rdata)
    );

    // Shared compare / index step
    assign w_ctl.down   = (r_req == REQ_DISP);
    assign w_ctl.single = (r_req == REQ_POP) || (r_req == REQ_PEEK);

    lss_walk #(
        .DEPTH (DEPTH)
    ) u_walk (
        .i_ctl      (w_ctl),
        .i_idx      (r_idx),
        .i_last_idx (r_last_idx),
        .i_word     (w_rdata),
        .i_key      (r_key),
        .o_sts      (w_sts),
        .o_nxt      (w_nxt)
    );

    // Search holds only when a pending match must go out and the port is busy
    assign w_stall = w_sts.match && r_have_pend && !w_out_free;

    // Sequencer
    always_comb begin
        n_state     = r_state;
        n_cnt       = r_cnt;
        n_ov        = r_ov;
        n_have_pend = r_have_pend;
        n_req       = r_req;
        n_key       = r_key;
        n_idx       = r_idx;
        n_last_idx  = r_last_idx;
        n_pend      = r_pend;
        n_status    = r_status;
        n_data      = r_data;
        n_pos       = r_pos;
        n_last      = r_last;

        if (o_res.ready) begin
            n_ov = 1'b0;
        end

        case (r_state)
            S_IDLE: begin
                if (w_in_fire) begin
                    case (i_req.req_type)
                        REQ_PUSH: begin
                            n_ov   = 1'b1;
                            n_last = 1'b1;
                            if (w_full) begin
                                n_status = ST_OVERFLOW;
                                n_data   = '0;
                                n_pos    = '0;
                            end else begin
                                n_status = ST_OK;
                                n_data   = i_req.value;
                                n_pos    = f_pos(r_cnt[IW-1:0]);
                                n_cnt    = r_cnt + CW'(1);
                            end
                        end
                        REQ_POP, REQ_PEEK, REQ_DISP, REQ_DRAIN, REQ_SEARCH: begin
                            if (r_cnt == '0) begin
                                n_ov     = 1'b1;
                                n_status = ST_UNDERFLW;
                                n_data   = '0;
                                n_pos    = '0;
                                n_last   = 1'b1;
                            end else begin
                                n_req       = i_req.req_type;
                                n_key       = i_req.value;
                                n_last_idx  = w_cnt_m1[IW-1:0];
                                n_have_pend = 1'b0;
                                n_state     = S_ADDR;
                                if ((i_req.req_type == REQ_DRAIN) ||
                                    (i_req.req_type == REQ_SEARCH)) begin
                                    n_idx = '0;
                                end else begin
                                    n_idx = w_cnt_m1[IW-1:0];
                                end
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end

            S_ADDR: begin
                n_state = S_DATA;
            end

            S_DATA: begin
                if (r_req == REQ_SEARCH) begin
                    if (!w_stall) begin
                        // earlier match goes out, this one waits
                        if (w_sts.match && r_have_pend) begin
                            n_ov     = 1'b1;
                            n_status = ST_OK;
                            n_data   = r_key;
                            n_pos    = f_pos(r_pend);
                            n_last   = 1'b0;
                        end
                        if (w_sts.match) begin
                            n_pend      = r_idx;
                            n_have_pend = 1'b1;
                        end
                        if (w_sts.at_end) begin
                            n_state = S_DONE;
                        end else begin
                            n_idx   = w_nxt;
                            n_state = S_ADDR;
                        end
                    end
                end else if (w_out_free) begin
                    n_ov     = 1'b1;
                    n_status = ST_OK;
                    n_data   = w_rdata;
                    n_pos    = f_pos(r_idx);
                    n_last   = w_sts.at_end;
                    if (w_sts.at_end) begin
                        n_state = S_IDLE;
                        if (r_req == REQ_POP) begin
                            n_cnt = w_cnt_m1;
                        end else if (r_req == REQ_DRAIN) begin
                            n_cnt = '0;
                        end
                    end else begin
                        n_idx   = w_nxt;
                        n_state = S_ADDR;
                    end
                end
            end

            S_DONE: begin
                // final search result: last match or not-found
                if (w_out_free) begin
                    n_ov        = 1'b1;
                    n_data      = r_key;
                    n_last      = 1'b1;
                    n_have_pend = 1'b0;
                    n_state     = S_IDLE;
                    if (r_have_pend) begin
                        n_status = ST_OK;
                        n_pos    = f_pos(r_pend);
                    end else begin
                        n_status = ST_NOTFOUND;
                        n_pos    = '0;
                    end
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_cnt       <= '0;
            r_ov        <= 1'b0;
            r_have_pend <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cnt       <= n_cnt;
            r_ov        <= n_ov;
            r_have_pend <= n_have_pend;
        end
    end

    // Payload
    always_ff @(posedge i_clk) begin
        r_req      <= n_req;
        r_key      <= n_key;
        r_idx      <= n_idx;
        r_last_idx <= n_last_idx;
        r_pend     <= n_pend;
        r_status   <= n_status;
        r_data     <= n_data;
        r_pos      <= n_pos;
        r_last     <= n_last;
    end

    // Result port
    assign o_res.valid    = r_ov;
    assign o_res.status   = r_status;
    assign o_res.data     = r_data;
    assign o_res.position = r_pos;
    assign o_res.last     = r_last;

    // Checks
    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= CW'(DEPTH))
        else $error("fill count beyond depth");

    a_walk_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_IDLE) |-> (r_cnt != '0))
        else $error("walk on an empty stack");

    a_pend_search: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_have_pend |-> ((r_req == REQ_SEARCH) && (r_state != S_IDLE)))
        else $error("pending match outside a search");

    a_addr_to_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_ADDR) |=> (r_state == S_DATA))
        else $error("read issued without data phase");

endmodule

[rtl/lss_ram.sv]
module lss_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 8
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Registered read, held while not enabled
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

[rtl/lss_walk.sv]
module lss_walk #(
    parameter int DEPTH = lss_pkg::DEPTH_DEF
) (
    input  lss_pkg::t_walk_ctl         i_ctl,
    input  logic [$clog2(DEPTH)-1:0]   i_idx,
    input  logic [$clog2(DEPTH)-1:0]   i_last_idx,
    input  lss_pkg::t_word             i_word,
    input  lss_pkg::t_word             i_key,
    output lss_pkg::t_walk_sts         o_sts,
    output logic [$clog2(DEPTH)-1:0]   o_nxt
);
    import lss_pkg::*;

    localparam int IW = $clog2(DEPTH);

    // Key compare
    assign o_sts.match = (i_word == i_key);

    // Index step, down for display and up otherwise
    assign o_nxt = i_ctl.down ? (i_idx - IW'(1)) : (i_idx + IW'(1));

    // End of walk
    assign o_sts.at_end = i_ctl.single ||
                          (i_ctl.down ? (i_idx == '0) : (i_idx == i_last_idx));

endmodule
